// ===== hw/rtl/mfr_pkg.sv =====
// Shared types, constants and compare helpers of the 3x3 median filter.
`default_nettype none
package mfr_pkg;

  localparam int WIN    = 3;
  localparam int QDEPTH = 4;
  localparam int ODEPTH = 4;
  localparam int CFG_W  = 11;
  localparam int CIW    = 2;

  typedef enum logic [CIW-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;
  } pix_t;

  typedef struct packed {
    logic [7:0] median_c0;
    logic [7:0] median_c1;
    logic [7:0] median_c2;
    logic [9:0] center_x;
    logic [9:0] center_y;
    logic       frame_last;
  } res_t;

  // window entry r*3+c, r = 0 oldest line, c = 0 leftmost column
  typedef struct packed {
    pix_t [8:0] win;
    logic [9:0] cx;
    logic [9:0] cy;
    logic       last;
  } job_t;

  function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [7:0] max8(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c);
    return max8(min8(a, b), min8(max8(a, b), c));
  endfunction

  // returns {max, median, min}
  function automatic logic [23:0] sort3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
    return {max8(max8(a, b), c), med3(a, b, c), min8(min8(a, b), c)};
  endfunction

  function automatic logic [7:0] get_ch(input pix_t p, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = p.pixel_c0;
      2'd1:    v = p.pixel_c1;
      2'd2:    v = p.pixel_c2;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mfr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_fifo.sv =====
// Small register FIFO with occupancy count.
`default_nettype none
module mfr_fifo #(
  parameter int  DEPTH  = 4,
  parameter type item_t = logic
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire item_t                      wdata_i,
  input  wire logic                       pop_i,
  output item_t                           rdata_o,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  item_t           mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_q];
  assign count_o = cnt_q;
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_front.sv =====
// Front end: raster position, line memory, 3x3 window and job issue.
`default_nettype none
module mfr_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire mfr_pkg::pix_t                     pix_i,
  output logic                                   full_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [mfr_pkg::CIW-1:0]           cfg_idx_i,
  input  wire logic [mfr_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  wire logic [$clog2(mfr_pkg::QDEPTH+1)-1:0] q_cnt_i,
  output logic                                   q_push_o,
  output mfr_pkg::job_t                          q_job_o
);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int HW = $clog2(MAX_HEIGHT+1);

  logic [mfr_pkg::CFG_W-1:0] width_q, height_q;
  logic [WW-1:0]             w_eff;
  logic [HW-1:0]             h_eff;
  logic [XW-1:0]             x_q, x_d;
  logic [YW-1:0]             y_q, y_d;
  logic                      accept, x_end, y_end;

  logic                      s1v_q, emit_q, last_q;
  mfr_pkg::pix_t             px_q;
  logic [XW-1:0]             x1_q;
  logic [9:0]                cx_q, cy_q;
  logic [47:0]               rd_data;
  mfr_pkg::pix_t             win_q [9];
  mfr_pkg::pix_t             win_d [9];

  always_comb begin
    if (width_q < mfr_pkg::CFG_W'(mfr_pkg::WIN)) begin
      w_eff = WW'(mfr_pkg::WIN);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < mfr_pkg::CFG_W'(mfr_pkg::WIN)) begin
      h_eff = HW'(mfr_pkg::WIN);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign full_o = (32'(q_cnt_i) + 32'(s1v_q)) >= mfr_pkg::QDEPTH;
  assign accept = push_i && !full_o;
  assign x_end  = (WW'(x_q) == w_eff - 1'b1);
  assign y_end  = (HW'(y_q) == h_eff - 1'b1);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cfg_we_i && (cfg_idx_i == mfr_pkg::CFG_WIDTH || cfg_idx_i == mfr_pkg::CFG_HEIGHT)) begin
      x_d = '0;
      y_d = '0;
    end else if (accept) begin
      if (x_end) begin
        x_d = '0;
        y_d = y_end ? '0 : y_q + 1'b1;
      end else begin
        x_d = x_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mfr_pkg::CFG_W'(1024);
      height_q <= mfr_pkg::CFG_W'(1024);
      x_q      <= '0;
      y_q      <= '0;
      s1v_q    <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == mfr_pkg::CFG_WIDTH) begin
        width_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_idx_i == mfr_pkg::CFG_HEIGHT) begin
        height_q <= cfg_wdata_i;
      end
      x_q   <= x_d;
      y_q   <= y_d;
      s1v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= pix_i;
      x1_q   <= x_q;
      emit_q <= (x_q >= XW'(2)) && (y_q >= YW'(2));
      last_q <= x_end && y_end;
      cx_q   <= 10'(x_q - XW'(1));
      cy_q   <= 10'(y_q - YW'(1));
    end
  end

  // one word per column: {older line, newer line}
  mfr_ram #(
    .WIDTH(48),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1v_q),
    .waddr_i (x1_q),
    .wdata_i ({rd_data[23:0], px_q}),
    .re_i    (accept),
    .raddr_i (x_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = rd_data[47:24];
    win_d[5] = rd_data[23:0];
    win_d[8] = px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1v_q) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  assign q_push_o = s1v_q && emit_q;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      q_job_o.win[i] = win_d[i];
    end
    q_job_o.cx   = cx_q;
    q_job_o.cy   = cy_q;
    q_job_o.last = last_q;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_back.sv =====
// Back end: three-stage median-of-nine network per channel.
`default_nettype none
module mfr_back (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [$clog2(mfr_pkg::QDEPTH+1)-1:0] q_cnt_i,
  input  wire mfr_pkg::job_t                        q_job_i,
  output logic                                      q_pop_o,
  input  wire logic [$clog2(mfr_pkg::ODEPTH+1)-1:0] o_cnt_i,
  output logic                                      o_push_o,
  output mfr_pkg::res_t                             o_res_o
);
  logic              va_q, vb_q;
  logic [23:0]       rows_q [3][3];
  logic [7:0]        lo_q [3], md_q [3], hi_q [3];
  logic [9:0]        cxa_q, cya_q, cxb_q, cyb_q;
  logic              lasta_q, lastb_q;
  logic [7:0]        med [3];

  // take a job only when the output FIFO has room for everything in flight
  assign q_pop_o = (q_cnt_i != '0) &&
                   ((32'(o_cnt_i) + 32'(va_q) + 32'(vb_q)) < mfr_pkg::ODEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      va_q <= q_pop_o;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        rows_q[c][r] <= mfr_pkg::sort3(mfr_pkg::get_ch(q_job_i.win[r*3], 2'(c)),
                                       mfr_pkg::get_ch(q_job_i.win[r*3+1], 2'(c)),
                                       mfr_pkg::get_ch(q_job_i.win[r*3+2], 2'(c)));
      end
      lo_q[c] <= mfr_pkg::max8(mfr_pkg::max8(rows_q[c][0][7:0], rows_q[c][1][7:0]),
                               rows_q[c][2][7:0]);
      md_q[c] <= mfr_pkg::med3(rows_q[c][0][15:8], rows_q[c][1][15:8],
                               rows_q[c][2][15:8]);
      hi_q[c] <= mfr_pkg::min8(mfr_pkg::min8(rows_q[c][0][23:16], rows_q[c][1][23:16]),
                               rows_q[c][2][23:16]);
    end
    cxa_q   <= q_job_i.cx;
    cya_q   <= q_job_i.cy;
    lasta_q <= q_job_i.last;
    cxb_q   <= cxa_q;
    cyb_q   <= cya_q;
    lastb_q <= lasta_q;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      med[c] = mfr_pkg::med3(lo_q[c], md_q[c], hi_q[c]);
    end
  end

  assign o_push_o = vb_q;
  always_comb begin
    o_res_o.median_c0  = med[0];
    o_res_o.median_c1  = med[1];
    o_res_o.median_c2  = med[2];
    o_res_o.center_x   = cxb_q;
    o_res_o.center_y   = cyb_q;
    o_res_o.frame_last = lastb_q;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/median_filter_3x3_rgb.sv =====
// Top level of the 3x3 per-channel median filter for RGB raster streams.
`default_nettype none
// Takes one pixel per clock in raster order while full is low and returns one
// result per clock, as pops allow, for every pixel that completes a full 3x3
// window; border pixels give none. The rate is set by the single line memory
// (one 48-bit word per column, read when a pixel is accepted and written back
// the cycle after) and by the median network, which is pipelined over two
// register stages. Line memory contents are not cleared after reset; the first
// two lines of a frame only fill it. Writes to the width or height register
// restart the frame at column 0, line 0.
module median_filter_3x3_rgb #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire mfr_pkg::pix_t             pix_i,
  output logic                           empty,
  input  wire logic                      pop,
  output mfr_pkg::res_t                  res_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [mfr_pkg::CIW-1:0]   cfg_idx_i,
  input  wire logic [mfr_pkg::CFG_W-1:0] cfg_wdata_i
);
  logic [$clog2(mfr_pkg::QDEPTH+1)-1:0] q_cnt;
  logic [$clog2(mfr_pkg::ODEPTH+1)-1:0] o_cnt;
  logic                                 q_push, q_pop, o_push;
  mfr_pkg::job_t                        q_wjob, q_rjob;
  mfr_pkg::res_t                        o_wres;

  mfr_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pix_i      (pix_i),
    .full_o     (full),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_cnt_i    (q_cnt),
    .q_push_o   (q_push),
    .q_job_o    (q_wjob)
  );

  mfr_fifo #(
    .DEPTH (mfr_pkg::QDEPTH),
    .item_t(mfr_pkg::job_t)
  ) u_jobq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wjob),
    .pop_i  (q_pop),
    .rdata_o(q_rjob),
    .count_o(q_cnt)
  );

  mfr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_cnt_i (q_cnt),
    .q_job_i (q_rjob),
    .q_pop_o (q_pop),
    .o_cnt_i (o_cnt),
    .o_push_o(o_push),
    .o_res_o (o_wres)
  );

  mfr_fifo #(
    .DEPTH (mfr_pkg::ODEPTH),
    .item_t(mfr_pkg::res_t)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (o_push),
    .wdata_i(o_wres),
    .pop_i  (pop && !empty),
    .rdata_o(res_o),
    .count_o(o_cnt)
  );

  assign empty = (o_cnt == '0);
endmodule
`default_nettype wire

// ===== hw/rtl/mfr_checker.sv =====
// Port-level assertions for the median filter, bound to the top level.
`default_nettype none
module mfr_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          push,
  input wire logic          full,
  input wire logic          empty,
  input wire logic          pop,
  input wire mfr_pkg::res_t res_o
);
  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(res_o))
    else $error("result changed while stalled");

  // with MAX_WIDTH and MAX_HEIGHT at most 1024, the centre is never on column 0 or line 0
  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> ((MAX_WIDTH > 1024) || (res_o.center_x != 10'd0)) &&
               ((MAX_HEIGHT > 1024) || (res_o.center_y != 10'd0)))
    else $error("result centre on border");

  // back-pressure only grows after an accepted item
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted item");
endmodule

bind median_filter_3x3_rgb mfr_checker #(
  .MAX_WIDTH (MAX_WIDTH),
  .MAX_HEIGHT(MAX_HEIGHT)
) u_chk (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .push  (push),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .res_o (res_o)
);
`default_nettype wire
